FILE: design/rvex_pkg.sv
package rvex_pkg;

   localparam int XLEN = 32;
   localparam int REG_COUNT = 32;
   localparam int REG_IDX_W = 5;
   localparam logic [XLEN-1:0] START_ADDRESS_DEFAULT = '0;

   localparam logic [6:0] OP_LUI    = 7'b0110111;
   localparam logic [6:0] OP_AUIPC  = 7'b0010111;
   localparam logic [6:0] OP_JAL    = 7'b1101111;
   localparam logic [6:0] OP_JALR   = 7'b1100111;
   localparam logic [6:0] OP_BRANCH = 7'b1100011;
   localparam logic [6:0] OP_LOAD   = 7'b0000011;
   localparam logic [6:0] OP_STORE  = 7'b0100011;
   localparam logic [6:0] OP_IMM    = 7'b0010011;
   localparam logic [6:0] OP_REG    = 7'b0110011;
   localparam logic [6:0] OP_FENCE  = 7'b0001111;
   localparam logic [6:0] OP_SYSTEM = 7'b1110011;
   localparam logic [6:0] F7_ALT    = 7'b0100000;
   localparam logic [31:0] JALR_MASK = 32'hFFFFFFFE;
   localparam logic [31:0] INSN_ECALL  = 32'h00000073;
   localparam logic [31:0] INSN_EBREAK = 32'h00100073;

   localparam logic [1:0] MEM_NONE  = 2'd0;
   localparam logic [1:0] MEM_READ  = 2'd1;
   localparam logic [1:0] MEM_WRITE = 2'd2;

   localparam logic [0:0] FUNC_EXEC = 1'b0;
   localparam logic [0:0] FUNC_LOAD = 1'b1;

   localparam logic [2:0] LD_B  = 3'd0;
   localparam logic [2:0] LD_H  = 3'd1;
   localparam logic [2:0] LD_BU = 3'd4;
   localparam logic [2:0] LD_HU = 3'd5;

   localparam logic [0:0] CSR_ADDR_START = 1'b0;

   typedef struct packed {
      logic [0:0]  func;
      logic [31:0] instr;
      logic [31:0] load_data;
   } req_type;

   typedef struct packed {
      logic [31:0] next_pc;
      logic [1:0]  mem_request;
      logic [31:0] mem_addr;
      logic [1:0]  mem_size;
      logic [31:0] mem_wdata;
      logic        reg_written;
      logic [4:0]  reg_index;
      logic [31:0] reg_value;
      logic        illegal;
      logic [1:0]  cycle_cost;
   } rsp_type;

   function automatic logic insn_legal(input logic [31:0] w);
      logic [6:0] op;
      logic [2:0] f3;
      logic [6:0] f7;
      logic ok;
      op = w[6:0];
      f3 = w[14:12];
      f7 = w[31:25];
      unique case (op)
         OP_LUI, OP_AUIPC, OP_JAL: ok = 1'b1;
         OP_JALR:   ok = (f3 == 3'd0);
         OP_BRANCH: ok = (f3 != 3'd2) && (f3 != 3'd3);
         OP_LOAD:   ok = (f3 != 3'd3) && (f3 != 3'd6) && (f3 != 3'd7);
         OP_STORE:  ok = (f3 <= 3'd2);
         OP_IMM: begin
            if (f3 == 3'd1) ok = (f7 == 7'd0);
            else if (f3 == 3'd5) ok = (f7 == 7'd0) || (f7 == F7_ALT);
            else ok = 1'b1;
         end
         OP_REG: ok = (f7 == 7'd0) || ((f7 == F7_ALT) && (f3 == 3'd0 || f3 == 3'd5));
         OP_FENCE: ok = (f3 == 3'd0) || (f3 == 3'd1);
         OP_SYSTEM: begin
            if (f3 == 3'd0) ok = (w == INSN_ECALL) || (w == INSN_EBREAK);
            else ok = (f3 != 3'd4);
         end
         default: ok = 1'b0;
      endcase
      return ok;
   endfunction

   function automatic logic [31:0] alu(input logic [2:0] f3, input logic alt,
                                       input logic [31:0] a, input logic [31:0] b);
      logic [31:0] r;
      unique case (f3)
         3'd0: r = alt ? a - b : a + b;
         3'd1: r = a << b[4:0];
         3'd2: r = {31'd0, $signed(a) < $signed(b)};
         3'd3: r = {31'd0, a < b};
         3'd4: r = a ^ b;
         3'd5: r = alt ? 32'($signed(a) >>> b[4:0]) : a >> b[4:0];
         3'd6: r = a | b;
         default: r = a & b;
      endcase
      return r;
   endfunction

endpackage

FILE: design/rvex_core.sv
module rvex_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              go,
   input  rvex_pkg::req_type req,
   input  logic              cfg_we,
   input  logic [31:0]       cfg_start,
   output rvex_pkg::rsp_type rsp
);
   import rvex_pkg::*;

   logic [31:0] regs_ff [1:REG_COUNT-1];
   logic [31:0] pc_ff, pc_in;
   logic        pend_ff, pend_in;
   logic [4:0]  ptgt_ff, ptgt_in;
   logic [2:0]  pkind_ff, pkind_in;

   logic [6:0]  op;
   logic [2:0]  f3;
   logic [4:0]  rs1, rs2, rdf;
   logic [31:0] r1, r2, immi, imms, immb, immj, d;
   logic        wr, ill, taken;
   logic [4:0]  rd;
   logic [31:0] val;

   assign op   = req.instr[6:0];
   assign f3   = req.instr[14:12];
   assign rs1  = req.instr[19:15];
   assign rs2  = req.instr[24:20];
   assign rdf  = req.instr[11:7];
   assign r1   = (rs1 == '0) ? '0 : regs_ff[rs1];
   assign r2   = (rs2 == '0) ? '0 : regs_ff[rs2];
   assign immi = {{20{req.instr[31]}}, req.instr[31:20]};
   assign imms = {{20{req.instr[31]}}, req.instr[31:25], req.instr[11:7]};
   assign immb = {{20{req.instr[31]}}, req.instr[7], req.instr[30:25],
                  req.instr[11:8], 1'b0};
   assign immj = {{12{req.instr[31]}}, req.instr[19:12], req.instr[20],
                  req.instr[30:21], 1'b0};

   always_comb begin
      unique case (f3)
         3'd0: taken = (r1 == r2);
         3'd1: taken = (r1 != r2);
         3'd4: taken = $signed(r1) < $signed(r2);
         3'd5: taken = !($signed(r1) < $signed(r2));
         3'd6: taken = r1 < r2;
         default: taken = r1 >= r2;
      endcase
      unique case (pkind_ff)
         LD_B:  d = {{24{req.load_data[7]}}, req.load_data[7:0]};
         LD_H:  d = {{16{req.load_data[15]}}, req.load_data[15:0]};
         LD_BU: d = {24'd0, req.load_data[7:0]};
         LD_HU: d = {16'd0, req.load_data[15:0]};
         default: d = req.load_data;
      endcase
   end

   always_comb begin
      rsp = '0;
      rsp.cycle_cost = 2'd1;
      pc_in = pc_ff;
      pend_in = pend_ff;
      ptgt_in = ptgt_ff;
      pkind_in = pkind_ff;
      wr = 1'b0;
      rd = '0;
      val = '0;
      ill = 1'b0;
      if (req.func == FUNC_LOAD) begin
         if (pend_ff) begin
            wr = 1'b1;
            rd = ptgt_ff;
            val = d;
            pend_in = 1'b0;
         end
      end else if (!insn_legal(req.instr)) begin
         ill = 1'b1;
      end else begin
         pc_in = pc_ff + 32'd4;
         rd = rdf;
         unique case (op)
            OP_LUI: begin
               wr = 1'b1; val = {req.instr[31:12], 12'd0};
            end
            OP_AUIPC: begin
               wr = 1'b1; val = pc_ff + {req.instr[31:12], 12'd0};
            end
            OP_JAL: begin
               wr = 1'b1; val = pc_ff + 32'd4; pc_in = pc_ff + immj;
            end
            OP_JALR: begin
               wr = 1'b1; val = pc_ff + 32'd4; pc_in = (r1 + immi) & JALR_MASK;
            end
            OP_BRANCH: begin
               if (taken) pc_in = pc_ff + immb;
               else rsp.cycle_cost = 2'd2;
            end
            OP_LOAD: begin
               rsp.mem_request = MEM_READ;
               rsp.mem_addr = r1 + immi;
               rsp.mem_size = {1'b0, f3[1:0]} == 3'd3 ? 2'd0 : f3[1:0];
               pend_in = 1'b1;
               ptgt_in = rdf;
               pkind_in = f3;
            end
            OP_STORE: begin
               rsp.mem_request = MEM_WRITE;
               rsp.mem_size = f3[1:0];
               rsp.mem_wdata = r2;
               rsp.mem_addr = r1 + imms;
            end
            OP_IMM: begin
               wr = 1'b1;
               val = alu(f3, (f3 == 3'd5) && (req.instr[31:25] == F7_ALT), r1,
                         (f3 == 3'd1 || f3 == 3'd5) ? {27'd0, req.instr[24:20]} : immi);
            end
            OP_REG: begin
               wr = 1'b1;
               val = alu(f3, req.instr[31:25] == F7_ALT, r1, r2);
            end
            default: ;
         endcase
      end
      if (!(wr && rd != '0)) begin
         wr = 1'b0; rd = '0; val = '0;
      end
      rsp.next_pc = ill ? pc_ff : ((req.func == FUNC_LOAD) ? pc_ff : pc_in);
      rsp.reg_written = wr;
      rsp.reg_index = rd;
      rsp.reg_value = val;
      rsp.illegal = ill;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= START_ADDRESS_DEFAULT;
         pend_ff <= 1'b0;
         ptgt_ff <= '0;
         pkind_ff <= '0;
      end else if (cfg_we) begin
         pc_ff <= cfg_start;
      end else if (go) begin
         pc_ff <= rsp.next_pc;
         pend_ff <= pend_in;
         ptgt_ff <= ptgt_in;
         pkind_ff <= pkind_in;
      end
   end

   // register file clears on reset, only 31 words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 1; i < REG_COUNT; i++) regs_ff[i] <= '0;
      end else if (go && wr) begin
         regs_ff[rd] <= val;
      end
   end

endmodule

FILE: design/rv32i_integer_execute_unit.sv
// rv32i integer execute unit
// request channel: req_valid / req_stall / req_data (func, instr, load_data).
// func 0 executes one instruction word; func 1 returns data for the pending load.
// response channel: rsp_valid / rsp_stall / rsp_data, exactly one response
// per request, in order.
// latency: a response is visible the cycle after its request is taken.
// throughput: one request per cycle unless req_stall is high; execution is
// one pass of decode, alu and register-file access, with the architectural
// state updated at acceptance; a stalled response holds in the output
// register, and a new request is taken in the same cycle the held response leaves.
// reset clears registers x1..x31, the pending load and sets pc to the
// start_address default; writing start_address (csr offset 0) loads the pc.
// csr reads of offset 0 return start_address.
module rv32i_integer_execute_unit (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  rvex_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output rvex_pkg::rsp_type rsp_data,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [1:0]        csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   import rvex_pkg::*;

   logic        rsp_valid_ff, rsp_valid_in;
   rsp_type     rsp_data_ff, rsp_comb;
   logic [31:0] start_ff;
   logic        go, cfg_we;

   assign csr_pready = 1'b1;
   assign cfg_we = csr_psel && csr_penable && csr_pwrite && (csr_paddr == 2'd0);
   assign csr_prdata = (csr_paddr == 2'd0) ? start_ff : '0;

   assign req_stall = rsp_valid_ff && rsp_stall;
   assign go = req_valid && !req_stall;
   assign rsp_valid_in = go || (rsp_valid_ff && rsp_stall);

   rvex_core u_core (
      .clock     (clock),
      .reset     (reset),
      .go        (go),
      .req       (req_data),
      .cfg_we    (cfg_we),
      .cfg_start (csr_pwdata),
      .rsp       (rsp_comb)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         start_ff <= START_ADDRESS_DEFAULT;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (cfg_we) start_ff <= csr_pwdata;
      end
      if (go) rsp_data_ff <= rsp_comb;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

FILE: design/rvex_checker.sv
module rvex_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input rvex_pkg::rsp_type rsp_data
);
   import rvex_pkg::*;

   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid) else $error("response missing");
   a_stall_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |-> req_stall) else $error("request taken over held response");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> $stable(rsp_data)) else $error("held response changed");
   a_illegal: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.illegal |-> !rsp_data.reg_written &&
      rsp_data.mem_request == MEM_NONE) else $error("illegal with side effect");

endmodule

bind rv32i_integer_execute_unit rvex_checker u_rvex_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
